// File: rtl/pli_pkg.sv
`default_nettype none
package pli_pkg;

  localparam int DATA_W    = 32;
  localparam int MAX_KNOTS = 64;
  localparam int ADDR_W    = $clog2(MAX_KNOTS);
  localparam int CNT_W     = $clog2(MAX_KNOTS + 1);
  localparam int PROD_W    = 2 * DATA_W;
  localparam int DIV_STEPS = DATA_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK             = 2'd0;
  localparam logic [1:0] ST_NOT_INCREASING = 2'd1;
  localparam logic [1:0] ST_FULL           = 2'd2;
  localparam logic [1:0] ST_TOO_FEW        = 2'd3;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] ordinate;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               status;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
    logic [DATA_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: rtl/pli_ram.sv
`default_nettype none
module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/pli_div.sv
`default_nettype none
module pli_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pli_pkg::div_req_t req,
  output pli_pkg::div_rsp_t      rsp
);
  import pli_pkg::*;

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] sh;
  logic [DATA_W-1:0] den;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;

  logic [DATA_W:0] trial;
  logic [DATA_W:0] diff;
  logic            ge;

  // restoring divide, one quotient bit per cycle; high half of dividend is below divisor
  assign trial = {rem, sh[DATA_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= req.dividend[PROD_W-1:DATA_W];
        sh   <= req.dividend[DATA_W-1:0];
        den  <= req.divisor;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        sh   <= {sh[DATA_W-2:0], ge};
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = sh;
  assign rsp.rem  = rem;

endmodule
`default_nettype wire

// File: rtl/piecewise_linear_interpolator.sv
`default_nettype none
// Knot table interpolator, one transaction in and one result out per command.
// An append to a nonempty table does one table read to check the last
// abscissa. A query with fewer than two knots returns the too-few status. A
// query at or below the first knot or at or above the last returns that knot's
// ordinate. Inside the table it runs a binary search of at most
// ceil(log2(knot_count-1)) steps, each one registered read of the knot memory.
// The rounded ratio comes from a 32-step bit-serial divider. The next
// transaction is taken once the previous result sits in the output register.
module piecewise_linear_interpolator (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         item_valid,
  output logic              item_stall,
  input  wire pli_pkg::in_t item,
  output logic              result_valid,
  input  wire logic         result_stall,
  output pli_pkg::out_t     result
);
  import pli_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_APP_CHK = 4'd1;
  localparam logic [3:0] S_Q_FIRST = 4'd2;
  localparam logic [3:0] S_Q_LAST  = 4'd3;
  localparam logic [3:0] S_SEARCH  = 4'd4;
  localparam logic [3:0] S_CMP     = 4'd5;
  localparam logic [3:0] S_FETCH0  = 4'd6;
  localparam logic [3:0] S_FETCH1  = 4'd7;
  localparam logic [3:0] S_PREP    = 4'd8;
  localparam logic [3:0] S_MUL     = 4'd9;
  localparam logic [3:0] S_DIVGO   = 4'd10;
  localparam logic [3:0] S_DIV     = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  logic [3:0]       state;
  logic [CNT_W-1:0] count;
  in_t              req;
  logic [ADDR_W-1:0] lo;
  logic [ADDR_W-1:0] hi;

  logic signed [DATA_W-1:0] x0;
  logic signed [DATA_W-1:0] y0;
  logic [DATA_W-1:0]        num;
  logic [DATA_W-1:0]        den;
  logic signed [DATA_W:0]   dy;
  logic [DATA_W-1:0]        mag;
  logic                     neg;
  logic [PROD_W-1:0]        prod;
  out_t                     res;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [DATA_W-1:0] rd_x_raw;
  logic [DATA_W-1:0] rd_y_raw;
  logic signed [DATA_W-1:0] rd_x;
  logic signed [DATA_W-1:0] rd_y;

  logic [CNT_W-1:0]  cnt_m1;
  logic [ADDR_W-1:0] last_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] mid;
  logic              out_free;
  logic              round_up;
  logic [DATA_W-1:0] q_rnd;
  logic [DATA_W:0]   dy_neg;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign rd_x      = $signed(rd_x_raw);
  assign rd_y      = $signed(rd_y_raw);
  assign cnt_m1    = count - CNT_W'(1);
  assign last_addr = cnt_m1[ADDR_W-1:0];
  assign wr_addr   = count[ADDR_W-1:0];
  assign mid       = lo + ((hi - lo) >> 1);
  assign out_free  = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE);
  assign dy_neg    = -dy;

  assign round_up = {div_rsp.rem, 1'b0} >= {1'b0, den};
  assign q_rnd    = div_rsp.quot + DATA_W'(round_up);

  assign div_req.start    = (state == S_DIVGO);
  assign div_req.dividend = prod;
  assign div_req.divisor  = den;

  pli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KNOTS)) u_abscissa (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req.position),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_x_raw)
  );

  pli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KNOTS)) u_ordinate (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req.ordinate),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_y_raw)
  );

  pli_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // memory strobes; writes use the captured transaction, so write the cycle after capture
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    unique case (state)
      S_IDLE: begin
      end
      S_APP_CHK: begin
        if (count == '0) begin
          wr_en = 1'b1;
        end else begin
          wr_en = req.position > rd_x;
        end
      end
      S_Q_FIRST: begin
        if (req.position > rd_x) begin
          rd_en   = 1'b1;
          rd_addr = last_addr;
        end
      end
      S_SEARCH: begin
        rd_en   = 1'b1;
        rd_addr = (lo < hi) ? mid : lo - ADDR_W'(1);
      end
      S_FETCH0: begin
        rd_en   = 1'b1;
        rd_addr = lo;
      end
      default: begin
      end
    endcase
    if (state == S_IDLE && item_valid) begin
      if (item.cmd == CMD_APPEND && count != '0) begin
        rd_en   = 1'b1;
        rd_addr = last_addr;
      end else if (item.cmd == CMD_QUERY) begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            req              <= item;
            res.result_value <= '0;
            unique case (item.cmd)
              CMD_CLEAR: begin
                count      <= '0;
                res.status <= ST_OK;
                state      <= S_DONE;
              end
              CMD_APPEND: begin
                if (count >= CNT_W'(MAX_KNOTS)) begin
                  res.status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  res.status <= ST_OK;
                  state      <= S_APP_CHK;
                end
              end
              CMD_QUERY: begin
                if (count < CNT_W'(2)) begin
                  res.status <= ST_TOO_FEW;
                  state      <= S_DONE;
                end else begin
                  res.status <= ST_OK;
                  state      <= S_Q_FIRST;
                end
              end
              default: begin
                res.status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_APP_CHK: begin
          if (wr_en) begin
            count <= count + CNT_W'(1);
          end else begin
            res.status <= ST_NOT_INCREASING;
          end
          state <= S_DONE;
        end
        S_Q_FIRST: begin
          if (req.position <= rd_x) begin
            res.result_value <= rd_y;
            state            <= S_DONE;
          end else begin
            state <= S_Q_LAST;
          end
        end
        S_Q_LAST: begin
          if (req.position >= rd_x) begin
            res.result_value <= rd_y;
            state            <= S_DONE;
          end else begin
            lo    <= ADDR_W'(1);
            hi    <= last_addr;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          state <= (lo < hi) ? S_CMP : S_FETCH0;
        end
        S_CMP: begin
          if (rd_x >= req.position) begin
            hi <= mid;
          end else begin
            lo <= mid + ADDR_W'(1);
          end
          state <= S_SEARCH;
        end
        S_FETCH0: begin
          x0    <= rd_x;
          y0    <= rd_y;
          state <= S_FETCH1;
        end
        S_FETCH1: begin
          num   <= req.position - x0;
          den   <= rd_x - x0;
          dy    <= {rd_y[DATA_W-1], rd_y} - {y0[DATA_W-1], y0};
          state <= S_PREP;
        end
        S_PREP: begin
          neg   <= dy[DATA_W];
          mag   <= dy[DATA_W] ? dy_neg[DATA_W-1:0] : dy[DATA_W-1:0];
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= num * mag;
          state <= S_DIVGO;
        end
        S_DIVGO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res.result_value <= neg ? y0 - $signed(q_rnd) : y0 + $signed(q_rnd);
            state            <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register frees up
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      result <= res;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_KNOTS))
    else $error("knot count beyond table size");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (count < CNT_W'(MAX_KNOTS)))
    else $error("knot write into a full table");

  a_search_lo: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (lo != '0) && (lo <= hi))
    else $error("binary search bounds broken");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVGO) |-> (den != '0))
    else $error("interval of zero width sent to divider");

  a_too_few_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_TOO_FEW) |-> (result.result_value == '0))
    else $error("error status with a nonzero value");

endmodule
`default_nettype wire
